@@ rtl/lzwc_pkg.sv @@
`timescale 1ns / 1ps

package lzwc_pkg;

   // single-byte codes sit below this, dictionary entries start here
   localparam int unsigned FIRST_ENTRY = 256;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned OUT_CODE_W  = 12;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SLOT,
      ST_ENTRY,
      ST_EMIT,
      ST_LAST
   } state_type;

endpackage

@@ rtl/lzwc_ram.sv @@
`timescale 1ns / 1ps

module lzwc_ram #(
   parameter int unsigned ADDR_W = 12,
   parameter int unsigned DATA_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] ram [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ram[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lzw_byte_compressor.sv @@
`timescale 1ns / 1ps
// LZW compressor, one byte per input word, up to two codes per byte.
// ST_IDLE takes a byte and reads its hash slot, ST_SLOT reads the entry of a live code,
// ST_ENTRY compares it, and a miss goes to ST_EMIT. Each further hash probe adds a slot
// read, then an entry read; end of stream adds ST_LAST, and a code waiting on rsp_ready
// holds the sequencer. A stream's first byte only sets the prefix. After reset the
// 2 * 2**clog2(DICT_ENTRIES) slots (8192 by default) are cleared with req_ready low.
module lzw_byte_compressor #(
   parameter int unsigned DICT_ENTRIES = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lzwc_pkg::BYTE_W-1:0]       req_in_byte,
   input  logic                              req_end_of_stream,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lzwc_pkg::OUT_CODE_W-1:0]   rsp_out_code,
   output logic                              rsp_final_code
);

   localparam int unsigned CODE_W  = $clog2(DICT_ENTRIES);
   localparam int unsigned SLOT_W  = CODE_W + 1;
   localparam int unsigned NFC_W   = CODE_W + 1;
   localparam int unsigned BW      = lzwc_pkg::BYTE_W;
   localparam int unsigned OCW     = lzwc_pkg::OUT_CODE_W;
   localparam int unsigned ENTRY_W = SLOT_W + CODE_W + BW;

   lzwc_pkg::state_type state_ff, state_in;

   logic [SLOT_W-1:0] clr_idx_ff, clr_idx_in;
   logic [BW-1:0]     byte_ff, byte_in;
   logic              last_ff, last_in;
   logic [CODE_W-1:0] prefix_ff, prefix_in;
   logic              present_ff, present_in;
   logic [NFC_W-1:0]  next_free_ff, next_free_in;
   logic [SLOT_W-1:0] probe_ff, probe_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic [CODE_W-1:0] emit_ff, emit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OCW-1:0]    rsp_code_ff, rsp_code_in;
   logic              rsp_final_ff, rsp_final_in;

   // slot table: hash slot -> code
   logic              slot_wr_en;
   logic [SLOT_W-1:0] slot_wr_addr;
   logic [CODE_W-1:0] slot_wr_data;
   logic              slot_rd_en;
   logic [SLOT_W-1:0] slot_rd_addr;
   logic [CODE_W-1:0] slot_rd_data;

   // entry table: code -> {owning slot, prefix, byte}
   logic               entry_wr_en;
   logic [CODE_W-1:0]  entry_wr_addr;
   logic [ENTRY_W-1:0] entry_wr_data;
   logic               entry_rd_en;
   logic [CODE_W-1:0]  entry_rd_addr;
   logic [ENTRY_W-1:0] entry_rd_data;

   logic [SLOT_W-1:0] e_slot;
   logic [CODE_W-1:0] e_prefix;
   logic [BW-1:0]     e_byte;
   logic [SLOT_W-1:0] hash;
   logic              slot_live;
   logic              out_free;
   logic              miss;
   logic [CODE_W+OCW-1:0] emit_wide;
   logic [CODE_W+OCW-1:0] prefix_wide;

   lzwc_ram #(.ADDR_W(SLOT_W), .DATA_W(CODE_W)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_data)
   );

   lzwc_ram #(.ADDR_W(CODE_W), .DATA_W(ENTRY_W)) u_entry_ram (
      .clock   (clock),
      .wr_en   (entry_wr_en),
      .wr_addr (entry_wr_addr),
      .wr_data (entry_wr_data),
      .rd_en   (entry_rd_en),
      .rd_addr (entry_rd_addr),
      .rd_data (entry_rd_data)
   );

   assign {e_slot, e_prefix, e_byte} = entry_rd_data;

   // fold byte into the upper bits of the slot index
   assign hash = {1'b0, prefix_ff} ^ {req_in_byte, {(SLOT_W-BW){1'b0}}};

   // a slot counts as taken only if its code is a live entry (FIRST_ENTRY..next_free-1)
   assign slot_live = (slot_rd_data >= CODE_W'(lzwc_pkg::FIRST_ENTRY))
                      && ({1'b0, slot_rd_data} < next_free_ff);

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign emit_wide   = {{OCW{1'b0}}, emit_ff};
   assign prefix_wide = {{OCW{1'b0}}, prefix_ff};

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lzwc_pkg::ST_CLEAR;
         clr_idx_ff   <= '0;
         prefix_ff    <= '0;
         present_ff   <= 1'b0;
         next_free_ff <= NFC_W'(lzwc_pkg::FIRST_ENTRY);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         prefix_ff    <= prefix_in;
         present_ff   <= present_in;
         next_free_ff <= next_free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      last_ff      <= last_in;
      probe_ff     <= probe_in;
      code_ff      <= code_in;
      emit_ff      <= emit_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_final_ff <= rsp_final_in;
   end

   // sequencer: slot clear, hash probe, entry check, insert, emit, end of stream flush
   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      byte_in       = byte_ff;
      last_in       = last_ff;
      prefix_in     = prefix_ff;
      present_in    = present_ff;
      next_free_in  = next_free_ff;
      probe_in      = probe_ff;
      code_in       = code_ff;
      emit_in       = emit_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_code_in   = rsp_code_ff;
      rsp_final_in  = rsp_final_ff;
      slot_wr_en    = 1'b0;
      slot_wr_addr  = probe_ff;
      slot_wr_data  = next_free_ff[CODE_W-1:0];
      slot_rd_en    = 1'b0;
      slot_rd_addr  = hash;
      entry_wr_en   = 1'b0;
      entry_wr_addr = next_free_ff[CODE_W-1:0];
      entry_wr_data = {probe_ff, prefix_ff, byte_ff};
      entry_rd_en   = 1'b0;
      entry_rd_addr = slot_rd_data;
      req_ready     = 1'b0;
      miss          = 1'b0;

      case (state_ff)
         lzwc_pkg::ST_CLEAR: begin
            slot_wr_en   = 1'b1;
            slot_wr_addr = clr_idx_ff;
            slot_wr_data = '0;
            clr_idx_in   = clr_idx_ff + 1'b1;
            if (clr_idx_ff == '1) begin
               state_in = lzwc_pkg::ST_IDLE;
            end
         end
         lzwc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               byte_in = req_in_byte;
               last_in = req_end_of_stream;
               if (!present_ff) begin
                  // first byte of a stream becomes the prefix
                  prefix_in  = {{(CODE_W-BW){1'b0}}, req_in_byte};
                  present_in = 1'b1;
                  state_in   = req_end_of_stream ? lzwc_pkg::ST_LAST : lzwc_pkg::ST_IDLE;
               end else begin
                  slot_rd_en   = 1'b1;
                  slot_rd_addr = hash;
                  probe_in     = hash;
                  state_in     = lzwc_pkg::ST_SLOT;
               end
            end
         end
         lzwc_pkg::ST_SLOT: begin
            code_in = slot_rd_data;
            if (slot_live) begin
               entry_rd_en   = 1'b1;
               entry_rd_addr = slot_rd_data;
               state_in      = lzwc_pkg::ST_ENTRY;
            end else begin
               miss = 1'b1;
            end
         end
         lzwc_pkg::ST_ENTRY: begin
            if (e_slot == probe_ff) begin
               if (e_prefix == prefix_ff && e_byte == byte_ff) begin
                  // prefix grows to the matching entry
                  prefix_in = code_ff;
                  state_in  = last_ff ? lzwc_pkg::ST_LAST : lzwc_pkg::ST_IDLE;
               end else begin
                  // occupied by another key, try the next slot
                  slot_rd_en   = 1'b1;
                  slot_rd_addr = probe_ff + 1'b1;
                  probe_in     = probe_ff + 1'b1;
                  state_in     = lzwc_pkg::ST_SLOT;
               end
            end else begin
               miss = 1'b1;
            end
         end
         lzwc_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = emit_wide[OCW-1:0];
               rsp_final_in = 1'b0;
               state_in     = last_ff ? lzwc_pkg::ST_LAST : lzwc_pkg::ST_IDLE;
            end
         end
         lzwc_pkg::ST_LAST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = prefix_wide[OCW-1:0];
               rsp_final_in = 1'b1;
               next_free_in = NFC_W'(lzwc_pkg::FIRST_ENTRY);
               prefix_in    = '0;
               present_in   = 1'b0;
               state_in     = lzwc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lzwc_pkg::ST_IDLE;
         end
      endcase

      // not found: emit prefix, insert at the probed slot if room, restart at byte
      if (miss) begin
         emit_in   = prefix_ff;
         prefix_in = {{(CODE_W-BW){1'b0}}, byte_ff};
         state_in  = lzwc_pkg::ST_EMIT;
         if (next_free_ff < NFC_W'(DICT_ENTRIES)) begin
            slot_wr_en   = 1'b1;
            slot_wr_addr = probe_ff;
            slot_wr_data = next_free_ff[CODE_W-1:0];
            entry_wr_en  = 1'b1;
            next_free_in = next_free_ff + 1'b1;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_code   = rsp_code_ff;
   assign rsp_final_code = rsp_final_ff;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

   localparam int unsigned BYTE_W       = lzwc_pkg::BYTE_W;
   localparam int unsigned OUT_CODE_W   = lzwc_pkg::OUT_CODE_W;
   localparam int unsigned FIRST_ENTRY  = lzwc_pkg::FIRST_ENTRY;
   localparam int unsigned DICT_ENTRIES = 4096;
   localparam int unsigned RANDOM_WORDS = 400;
   // covers the slot table clear after reset
   localparam int unsigned STALL_LIMIT  = 100000;
   localparam int unsigned KEY_W        = OUT_CODE_W + BYTE_W;

   typedef struct packed {
      logic [OUT_CODE_W-1:0] code;
      logic                  last;
   } code_word_type;

   typedef struct packed {
      logic [BYTE_W-1:0]     data;
      logic                  eos;
      logic                  typed;
      logic [1:0]            n_codes;
      logic [OUT_CODE_W-1:0] code0;
      logic                  last0;
      logic [OUT_CODE_W-1:0] code1;
      logic                  last1;
   } stim_row_type;

   typedef enum int {READY_ALWAYS, READY_RANDOM, READY_PATTERN} ready_mode_type;
   typedef enum int {TEXT_RANDOM, TEXT_FOUR, TEXT_TWO, TEXT_REPEAT} text_kind_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [BYTE_W-1:0]     req_in_byte = '0;
   logic                  req_end_of_stream = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [OUT_CODE_W-1:0] rsp_out_code;
   logic                  rsp_final_code;

   // encoder mirror
   logic [OUT_CODE_W-1:0] dict_code [bit [KEY_W-1:0]];
   int unsigned           next_code = FIRST_ENTRY;
   logic [OUT_CODE_W-1:0] prefix_code = '0;
   logic                  prefix_valid = 1'b0;
   code_word_type         step_codes[$];
   code_word_type         pending_codes[$];

   int unsigned           mismatches = 0;
   int unsigned           idle_cycles = 0;
   int unsigned           burst_left = 0;
   int unsigned           random_words = 0;
   ready_mode_type        ready_mode = READY_ALWAYS;
   int unsigned           ready_mode_left = 0;
   logic [7:0]            ready_pattern = 8'hff;

   // data, eos, typed, n, code0, last0, code1, last1
   stim_row_type directed_rows [20] = '{
      '{8'h00, 1'b1, 1'b1, 2'd1, 12'd0,   1'b1, 12'd0,   1'b0},
      '{8'hff, 1'b1, 1'b1, 2'd1, 12'd255, 1'b1, 12'd0,   1'b0},
      '{8'h00, 1'b0, 1'b1, 2'd0, 12'd0,   1'b0, 12'd0,   1'b0},
      '{8'h00, 1'b0, 1'b1, 2'd1, 12'd0,   1'b0, 12'd0,   1'b0},
      '{8'h00, 1'b0, 1'b1, 2'd0, 12'd0,   1'b0, 12'd0,   1'b0},
      '{8'h00, 1'b1, 1'b1, 2'd2, 12'd256, 1'b0, 12'd0,   1'b1},
      '{8'hff, 1'b0, 1'b1, 2'd0, 12'd0,   1'b0, 12'd0,   1'b0},
      '{8'hff, 1'b0, 1'b1, 2'd1, 12'd255, 1'b0, 12'd0,   1'b0},
      '{8'hff, 1'b0, 1'b1, 2'd0, 12'd0,   1'b0, 12'd0,   1'b0},
      '{8'hff, 1'b1, 1'b1, 2'd2, 12'd256, 1'b0, 12'd255, 1'b1},
      '{8'h41, 1'b0, 1'b0, 2'd0, 12'd0,   1'b0, 12'd0,   1'b0},
      '{8'h42, 1'b0, 1'b0, 2'd0, 12'd0,   1'b0, 12'd0,   1'b0},
      '{8'h41, 1'b0, 1'b0, 2'd0, 12'd0,   1'b0, 12'd0,   1'b0},
      '{8'h42, 1'b0, 1'b0, 2'd0, 12'd0,   1'b0, 12'd0,   1'b0},
      '{8'h41, 1'b0, 1'b0, 2'd0, 12'd0,   1'b0, 12'd0,   1'b0},
      '{8'h42, 1'b0, 1'b0, 2'd0, 12'd0,   1'b0, 12'd0,   1'b0},
      '{8'h41, 1'b1, 1'b0, 2'd0, 12'd0,   1'b0, 12'd0,   1'b0},
      '{8'h80, 1'b0, 1'b0, 2'd0, 12'd0,   1'b0, 12'd0,   1'b0},
      '{8'h01, 1'b0, 1'b0, 2'd0, 12'd0,   1'b0, 12'd0,   1'b0},
      '{8'h7f, 1'b1, 1'b0, 2'd0, 12'd0,   1'b0, 12'd0,   1'b0}
   };

   lzw_byte_compressor #(
      .DICT_ENTRIES(DICT_ENTRIES)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_end_of_stream(req_end_of_stream),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_code     (rsp_out_code),
      .rsp_final_code   (rsp_final_code)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (mismatches < 100) begin
         $display("mismatch at %0t: %s", $realtime, msg);
      end
      mismatches++;
   endtask

   // next codes of the encoder for one byte, left in step_codes
   task automatic encode_byte(input logic [BYTE_W-1:0] data, input logic eos);
      bit [KEY_W-1:0] key;
      code_word_type  w;
      step_codes.delete();
      key = {prefix_code, data};
      if (!prefix_valid) begin
         prefix_code = data;
         prefix_valid = 1'b1;
      end else if (dict_code.exists(key)) begin
         prefix_code = dict_code[key];
      end else begin
         w.code = prefix_code;
         w.last = 1'b0;
         step_codes.push_back(w);
         // a full dictionary stays as it is
         if (next_code < DICT_ENTRIES) begin
            dict_code[key] = OUT_CODE_W'(next_code);
            next_code++;
         end
         prefix_code = data;
      end
      // end of stream flushes the prefix and empties the dictionary
      if (eos) begin
         w.code = prefix_code;
         w.last = 1'b1;
         step_codes.push_back(w);
         dict_code.delete();
         next_code = FIRST_ENTRY;
         prefix_code = '0;
         prefix_valid = 1'b0;
      end
   endtask

   // present one word, with bursts and gaps on the sender side
   task automatic drive_word(input logic [BYTE_W-1:0] data, input logic eos);
      @(negedge clock);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         req_in_byte <= BYTE_W'($urandom);
         req_end_of_stream <= 1'($urandom);
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(80, 300)
                                                  : $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_in_byte <= data;
      req_end_of_stream <= eos;
      do @(posedge clock); while (!req_ready);
      burst_left--;
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] data, input logic eos);
      drive_word(data, eos);
      encode_byte(data, eos);
      foreach (step_codes[i]) pending_codes.push_back(step_codes[i]);
   endtask

   // one stream of random text shaped by kind
   task automatic send_stream(input int unsigned len, input text_kind_type kind);
      logic [BYTE_W-1:0] symbols [4];
      logic [BYTE_W-1:0] data;
      int unsigned       period;
      foreach (symbols[i]) symbols[i] = BYTE_W'($urandom);
      if ($urandom_range(0, 3) == 0) begin
         symbols[0] = 8'h00;
         symbols[1] = 8'hff;
      end
      period = $urandom_range(1, 4);
      for (int unsigned i = 0; i < len; i++) begin
         case (kind)
            TEXT_FOUR:   data = symbols[$urandom_range(0, 3)];
            TEXT_TWO:    data = symbols[$urandom_range(0, 1)];
            TEXT_REPEAT: data = ($urandom_range(0, 15) == 0) ? BYTE_W'($urandom)
                                                             : symbols[i % period];
            default:     data = BYTE_W'($urandom);
         endcase
         send_byte(data, i == len - 1);
      end
   endtask

   // receiver stall pattern
   always @(negedge clock) begin
      if (ready_mode_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 2));
         ready_mode_left = $urandom_range(16, 300);
         ready_pattern = 8'($urandom) | 8'h01;
      end
      ready_mode_left--;
      case (ready_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_RANDOM: rsp_ready <= 1'($urandom);
         default:      rsp_ready <= ready_pattern[ready_mode_left % 8];
      endcase
   end

   // compare each code word against the oldest pending one
   always @(posedge clock) begin
      code_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_codes.size() == 0) begin
            report_mismatch($sformatf("code %0d final %0b with nothing pending",
                                      rsp_out_code, rsp_final_code));
         end else begin
            want = pending_codes.pop_front();
            if (rsp_out_code !== want.code) begin
               report_mismatch($sformatf("out_code %0d, want %0d", rsp_out_code, want.code));
            end
            if (rsp_final_code !== want.last) begin
               report_mismatch($sformatf("final_code %0b, want %0b", rsp_final_code,
                                         want.last));
            end
         end
      end
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("** lzw_byte_compressor: FAILED **");
         $finish;
      end
   end

   initial begin
      int unsigned   len;
      int unsigned   pick;
      code_word_type w;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < $size(directed_rows); i++) begin
         drive_word(directed_rows[i].data, directed_rows[i].eos);
         encode_byte(directed_rows[i].data, directed_rows[i].eos);
         if (directed_rows[i].typed) begin
            if (directed_rows[i].n_codes > 0) begin
               w.code = directed_rows[i].code0;
               w.last = directed_rows[i].last0;
               pending_codes.push_back(w);
            end
            if (directed_rows[i].n_codes > 1) begin
               w.code = directed_rows[i].code1;
               w.last = directed_rows[i].last1;
               pending_codes.push_back(w);
            end
         end else begin
            foreach (step_codes[k]) pending_codes.push_back(step_codes[k]);
         end
      end

      // random streams
      while (random_words < RANDOM_WORDS) begin
         pick = $urandom_range(0, 9);
         if (pick < 2) begin
            len = 1;
         end else if (pick < 5) begin
            len = $urandom_range(2, 8);
         end else begin
            len = $urandom_range(9, 60);
         end
         send_stream(len, text_kind_type'($urandom_range(0, 3)));
         random_words += len;
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // drain
      while (pending_codes.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && pending_codes.size() == 0) begin
         $display("** lzw_byte_compressor: PASSED **");
      end else begin
         $display("** lzw_byte_compressor: FAILED **");
      end
      $finish;
   end

endmodule

@@ lzw_byte_compressor.f @@
rtl/lzwc_pkg.sv
rtl/lzwc_ram.sv
rtl/lzw_byte_compressor.sv
tb/tb.sv
